[hdl/ldhb_pkg.sv]
`default_nettype none

package ldhb_pkg;

    // Event codes carried on the result channel.
    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_PAYLOAD       = 3'd1,
        EV_EMPTY_FRAME   = 3'd2,
        EV_SEND_REPLY    = 3'd3,
        EV_REPLY_SEEN    = 3'd4,
        EV_SEND_HEARTBEAT = 3'd5,
        EV_LENGTH_CLOSE  = 3'd6,
        EV_TIMEOUT_CLOSE = 3'd7
    } event_t;

    // Input beat kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Frame layout.
    localparam int LEN_BYTES     = 4;
    localparam int HDR_BYTES     = 6;
    localparam int MIN_FRAME_LEN = 6;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME_LENGTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HB_REQUEST_ID    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HB_REPLY_ID      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REPLY_TIMEOUT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEND_INTERVAL    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HB_ENABLE        = 3'd5;

    localparam logic [16:0] RST_MAX_FRAME_LENGTH = 17'd4096;
    localparam logic [15:0] RST_HB_REQUEST_ID    = 16'd1;
    localparam logic [15:0] RST_HB_REPLY_ID      = 16'd2;
    localparam logic [31:0] RST_REPLY_TIMEOUT    = 32'd10000;
    localparam logic [31:0] RST_SEND_INTERVAL    = 32'd15000;
    localparam logic        RST_HB_ENABLE        = 1'b1;

    typedef struct packed {
        logic [16:0] max_frame_length;
        logic [15:0] heartbeat_request_id;
        logic [15:0] hb_reply_id;
        logic [31:0] reply_timeout_ms;
        logic [31:0] send_interval_ms;
        logic        heartbeat_enable;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/ldhb_intf.sv]
`default_nettype none

interface ldhb_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface ldhb_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic [7:0]         out_byte;
    logic [15:0]        frame_id;
    logic               last;
    logic signed [31:0] ping_ms;

    modport source (output valid, output event_res, output out_byte, output frame_id,
                    output last, output ping_ms, input ready);
    modport sink   (input valid, input event_res, input out_byte, input frame_id,
                    input last, input ping_ms, output ready);
endinterface

`default_nettype wire

[hdl/ldhb_cfg.sv]
`default_nettype none

module ldhb_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ldhb_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ldhb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ldhb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output ldhb_pkg::cfg_t                         cfg
);

    ldhb_pkg::cfg_t                   cfg_reg;
    ldhb_pkg::cfg_t                   cfg_next;
    logic [ldhb_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ldhb_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                ldhb_pkg::REG_MAX_FRAME_LENGTH: cfg_next.max_frame_length     = pwdata[16:0];
                ldhb_pkg::REG_HB_REQUEST_ID:    cfg_next.heartbeat_request_id = pwdata[15:0];
                ldhb_pkg::REG_HB_REPLY_ID:      cfg_next.hb_reply_id          = pwdata[15:0];
                ldhb_pkg::REG_REPLY_TIMEOUT:    cfg_next.reply_timeout_ms     = pwdata;
                ldhb_pkg::REG_SEND_INTERVAL:    cfg_next.send_interval_ms     = pwdata;
                ldhb_pkg::REG_HB_ENABLE:        cfg_next.heartbeat_enable     = pwdata[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ldhb_pkg::REG_MAX_FRAME_LENGTH: prdata = {15'd0, cfg_reg.max_frame_length};
            ldhb_pkg::REG_HB_REQUEST_ID:    prdata = {16'd0, cfg_reg.heartbeat_request_id};
            ldhb_pkg::REG_HB_REPLY_ID:      prdata = {16'd0, cfg_reg.hb_reply_id};
            ldhb_pkg::REG_REPLY_TIMEOUT:    prdata = cfg_reg.reply_timeout_ms;
            ldhb_pkg::REG_SEND_INTERVAL:    prdata = cfg_reg.send_interval_ms;
            ldhb_pkg::REG_HB_ENABLE:        prdata = {31'd0, cfg_reg.heartbeat_enable};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_length     <= ldhb_pkg::RST_MAX_FRAME_LENGTH;
            cfg_reg.heartbeat_request_id <= ldhb_pkg::RST_HB_REQUEST_ID;
            cfg_reg.hb_reply_id          <= ldhb_pkg::RST_HB_REPLY_ID;
            cfg_reg.reply_timeout_ms     <= ldhb_pkg::RST_REPLY_TIMEOUT;
            cfg_reg.send_interval_ms     <= ldhb_pkg::RST_SEND_INTERVAL;
            cfg_reg.heartbeat_enable     <= ldhb_pkg::RST_HB_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hdl/ldhb_engine.sv]
`default_nettype none

module ldhb_engine #(
    parameter int MAX_FRAME_LIMIT = 65536
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ldhb_pkg::cfg_t  cfg,
    ldhb_in_if.sink              ingress,
    ldhb_out_if.source           egress
);

    localparam int PW = $clog2(MAX_FRAME_LIMIT + 1);

    // Input stage.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        kind_reg;
    logic [7:0]  byte_reg;

    // Parser and supervisor state.
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [31:0]   flen_reg;
    logic [31:0]   flen_next;
    logic [15:0]   id_reg;
    logic [15:0]   id_next;
    logic          closed_reg;
    logic          closed_next;
    logic [31:0]   now_reg;
    logic [31:0]   now_next;
    logic [31:0]   sent_reg;
    logic [31:0]   sent_next;
    logic [31:0]   seen_reg;
    logic [31:0]   seen_next;
    logic [31:0]   ping_reg;
    logic [31:0]   ping_next;

    // Result stage.
    logic             out_valid_reg;
    logic             out_valid_next;
    ldhb_pkg::event_t ev_reg;
    ldhb_pkg::event_t ev_next;
    logic [7:0]       obyte_reg;
    logic [7:0]       obyte_next;
    logic [15:0]      fid_reg;
    logic [15:0]      fid_next;
    logic             last_reg;
    logic             last_next;

    logic          advance;
    logic [PW-1:0] pos_inc;
    logic [31:0]   flen_shift;
    logic [15:0]   id_shift;
    logic [15:0]   end_id;
    logic          end_is_req;
    logic          end_is_rep;
    logic          cur_is_hb;
    logic [31:0]   limit;
    logic [31:0]   now_inc;
    logic [31:0]   since;

    assign advance       = in_valid_reg && (!out_valid_reg || egress.ready);
    assign ingress.ready = !in_valid_reg || advance;
    assign in_valid_next = ingress.ready ? ingress.valid : in_valid_reg;

    assign pos_inc    = pos_reg + PW'(1);
    assign flen_shift = {flen_reg[23:0], byte_reg};
    assign id_shift   = {id_reg[7:0], byte_reg};
    assign end_id     = (pos_reg < PW'(ldhb_pkg::HDR_BYTES)) ? id_shift : id_reg;
    assign end_is_req = (end_id == cfg.heartbeat_request_id);
    assign end_is_rep = (end_id == cfg.hb_reply_id);
    assign cur_is_hb  = (id_reg == cfg.heartbeat_request_id) ||
                        (id_reg == cfg.hb_reply_id);
    assign limit      = ({15'd0, cfg.max_frame_length} > 32'(MAX_FRAME_LIMIT)) ?
                        32'(MAX_FRAME_LIMIT) : {15'd0, cfg.max_frame_length};
    assign now_inc    = now_reg + 32'd1;
    assign since      = now_inc - sent_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        flen_next   = flen_reg;
        id_next     = id_reg;
        closed_next = closed_reg;
        now_next    = now_reg;
        sent_next   = sent_reg;
        seen_next   = seen_reg;
        ping_next   = ping_reg;
        ev_next     = ldhb_pkg::EV_NONE;
        obyte_next  = 8'd0;
        fid_next    = 16'd0;
        last_next   = 1'b0;

        if (kind_reg == ldhb_pkg::KIND_TICK)
        begin
            now_next = now_inc;
            if (!closed_reg && cfg.heartbeat_enable)
            begin
                priority if ((sent_reg > seen_reg) && (since > cfg.reply_timeout_ms))
                begin
                    closed_next = 1'b1;
                    ev_next     = ldhb_pkg::EV_TIMEOUT_CLOSE;
                end
                else if (since > cfg.send_interval_ms)
                begin
                    sent_next = now_inc;
                    ev_next   = ldhb_pkg::EV_SEND_HEARTBEAT;
                end
            end
        end
        else if (!closed_reg)
        begin
            priority if (pos_reg < PW'(ldhb_pkg::LEN_BYTES))
            begin
                flen_next = flen_shift;
                pos_next  = pos_inc;
                if ((pos_inc == PW'(ldhb_pkg::LEN_BYTES)) &&
                    ((flen_shift < 32'(ldhb_pkg::MIN_FRAME_LEN)) || (flen_shift > limit)))
                begin
                    closed_next = 1'b1;
                    ev_next     = ldhb_pkg::EV_LENGTH_CLOSE;
                end
            end
            else if (pos_reg < PW'(ldhb_pkg::HDR_BYTES))
            begin
                id_next  = id_shift;
                pos_next = pos_inc;
                if ((pos_inc == PW'(ldhb_pkg::HDR_BYTES)) &&
                    (flen_reg == 32'(ldhb_pkg::MIN_FRAME_LEN)))
                begin
                    // A frame with no payload ends on its last id byte.
                    pos_next = '0;
                    priority if (end_is_req)
                        ev_next = ldhb_pkg::EV_SEND_REPLY;
                    else if (end_is_rep)
                    begin
                        seen_next = now_reg;
                        ping_next = now_reg - sent_reg;
                        ev_next   = ldhb_pkg::EV_REPLY_SEEN;
                    end
                    else
                    begin
                        ev_next  = ldhb_pkg::EV_EMPTY_FRAME;
                        fid_next = id_shift;
                    end
                end
            end
            else
            begin
                pos_next = pos_inc;
                if (32'(pos_inc) >= flen_reg)
                begin
                    pos_next  = '0;
                    flen_next = 32'd0;
                    priority if (end_is_req)
                        ev_next = ldhb_pkg::EV_SEND_REPLY;
                    else if (end_is_rep)
                    begin
                        seen_next = now_reg;
                        ping_next = now_reg - sent_reg;
                        ev_next   = ldhb_pkg::EV_REPLY_SEEN;
                    end
                    else
                    begin
                        ev_next    = ldhb_pkg::EV_PAYLOAD;
                        obyte_next = byte_reg;
                        fid_next   = id_reg;
                        last_next  = 1'b1;
                    end
                end
                else if (!cur_is_hb)
                begin
                    ev_next    = ldhb_pkg::EV_PAYLOAD;
                    obyte_next = byte_reg;
                    fid_next   = id_reg;
                end
            end
        end
    end

    always_comb
    begin
        priority if (advance)
            out_valid_next = 1'b1;
        else if (egress.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            flen_reg      <= 32'd0;
            id_reg        <= 16'd0;
            closed_reg    <= 1'b0;
            now_reg       <= 32'd0;
            sent_reg      <= 32'd0;
            seen_reg      <= 32'd0;
            ping_reg      <= 32'hFFFF_FFFF;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pos_reg    <= pos_next;
                flen_reg   <= flen_next;
                id_reg     <= id_next;
                closed_reg <= closed_next;
                now_reg    <= now_next;
                sent_reg   <= sent_next;
                seen_reg   <= seen_next;
                ping_reg   <= ping_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ingress.ready && ingress.valid)
        begin
            kind_reg <= ingress.kind;
            byte_reg <= ingress.data_byte;
        end
        if (advance)
        begin
            ev_reg    <= ev_next;
            obyte_reg <= obyte_next;
            fid_reg   <= fid_next;
            last_reg  <= last_next;
        end
    end

    assign egress.valid     = out_valid_reg;
    assign egress.event_res = ev_reg;
    assign egress.out_byte  = obyte_reg;
    assign egress.frame_id  = fid_reg;
    assign egress.last      = last_reg;
    assign egress.ping_ms   = signed'(ping_reg);

`ifndef NO_ASSERTIONS
    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("session reopened after close");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg >= PW'(ldhb_pkg::HDR_BYTES)) |-> (32'(pos_reg) < flen_reg))
        else $error("byte position ran past frame length");

    a_closed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && closed_reg) |=> (ev_reg == ldhb_pkg::EV_NONE))
        else $error("event produced on closed session");

    a_len_close: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (ev_next == ldhb_pkg::EV_LENGTH_CLOSE)) |=> closed_reg)
        else $error("length close did not close session");
`endif

endmodule

`default_nettype wire

[hdl/length_prefixed_deframer_heartbeat_core.sv]
// An accepted input beat waits in the input register and passes to the result register
// when that is free; one input beat per cycle while egress keeps pace, one result each.
// The input register and the result register sit around one pass of parser and
// supervisor logic, so input is taken while a finished result waits downstream.
// Reset (rst_n, asynchronous, active low) clears the parser, the millisecond clock
// and the session; configuration registers return to their documented defaults.
`default_nettype none

module length_prefixed_deframer_heartbeat_core #(
    parameter int MAX_FRAME_LIMIT = 65536
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ldhb_in_if.sink                                ingress,
    ldhb_out_if.source                             egress,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ldhb_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ldhb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ldhb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    // Configuration registers: the limit in force on frame length is the
    // smaller of the programmed maximum and MAX_FRAME_LIMIT.
    ldhb_pkg::cfg_t cfg;

    ldhb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The engine parses the length and id header, passes payload bytes on,
    // answers heartbeat frames and runs the tick-driven heartbeat supervisor.
    // A bad length or an overdue reply closes the session until reset.
    ldhb_engine #(
        .MAX_FRAME_LIMIT (MAX_FRAME_LIMIT)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .ingress (ingress),
        .egress  (egress)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    // The parser clamps the configured maximum frame length to this build-time cap.
    localparam int FRAME_LIMIT_CAP = 65536;
    // A result beat passes the input register and then the result register, so these
    // extra cycles are enough to be sure the pipeline is empty.
    localparam int SETTLE_CYCLES = 6;
    // Cycles with no beat moving on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } ingress_beat_t;

    typedef struct packed {
        ldhb_pkg::event_t ev;
        logic [7:0]       data;
        logic [15:0]      id;
        logic             last;
        logic [31:0]      ping;
    } deframe_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ldhb_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ldhb_pkg::APB_DATA_W-1:0] pwdata = '0;
    wire  [ldhb_pkg::APB_DATA_W-1:0] prdata;
    wire                             pready;

    ldhb_in_if  beat_in ();
    ldhb_out_if beat_out ();

    length_prefixed_deframer_heartbeat_core #(
        .MAX_FRAME_LIMIT(FRAME_LIMIT_CAP)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .ingress(beat_in),
        .egress (beat_out),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Beats waiting for the driver, and the result beats the parser must produce
    // for them, oldest first.
    ingress_beat_t   pending_beats[$];
    deframe_result_t predicted_events[$];

    int unsigned beats_queued = 0;
    int unsigned tick_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          cycle_count = 0;
    logic        steady;

    // Shadow of the configuration registers and of the parser and supervisor state.
    ldhb_pkg::cfg_t shadow_cfg;
    logic [16:0] parse_pos = '0;
    logic [31:0] frame_len = '0;
    logic [15:0] frame_ident = '0;
    logic        session_down = 1'b0;
    logic [31:0] clock_ms = '0;
    logic [31:0] hb_sent_ms = '0;
    logic [31:0] hb_seen_ms = '0;
    logic [31:0] ping_value = 32'hFFFF_FFFF;

    ingress_beat_t   next_beat;
    deframe_result_t want;

    // Neither the driver nor the monitor inserts random idle cycles inside this window,
    // so that back-to-back beats are seen for a good while.
    assign steady = (cycle_count >= 600) && (cycle_count < 1100);

    function automatic logic [31:0] frame_limit();
        if (shadow_cfg.max_frame_length > FRAME_LIMIT_CAP)
            return 32'(FRAME_LIMIT_CAP);
        return {15'd0, shadow_cfg.max_frame_length};
    endfunction

    // End of a frame: the id decides between a heartbeat request, a heartbeat
    // reply (which takes a round-trip measurement) and an ordinary data frame.
    // A frame whose id matches both heartbeat ids counts as a request.
    function automatic ldhb_pkg::event_t frame_end_event();
        if (frame_ident == shadow_cfg.heartbeat_request_id)
            return ldhb_pkg::EV_SEND_REPLY;
        if (frame_ident == shadow_cfg.hb_reply_id)
        begin
            hb_seen_ms = clock_ms;
            ping_value = clock_ms - hb_sent_ms;
            return ldhb_pkg::EV_REPLY_SEEN;
        end
        return ldhb_pkg::EV_EMPTY_FRAME;
    endfunction

    // Advances the shadow state by one input beat and returns the result beat
    // that the parser must give for it.
    function automatic deframe_result_t deframe_step(input logic kind,
                                                     input logic [7:0] value);
        deframe_result_t r;
        logic [31:0]     since;

        r = '{ev: ldhb_pkg::EV_NONE, data: 8'd0, id: 16'd0, last: 1'b0, ping: 32'd0};
        if (kind == ldhb_pkg::KIND_TICK)
        begin
            // The millisecond clock runs even when the session is closed.
            clock_ms = clock_ms + 32'd1;
            since = clock_ms - hb_sent_ms;
            if (!session_down && shadow_cfg.heartbeat_enable)
            begin
                // An overdue reply wins over sending the next heartbeat.
                if (hb_sent_ms > hb_seen_ms && since > shadow_cfg.reply_timeout_ms)
                begin
                    session_down = 1'b1;
                    r.ev = ldhb_pkg::EV_TIMEOUT_CLOSE;
                end
                else if (since > shadow_cfg.send_interval_ms)
                begin
                    hb_sent_ms = clock_ms;
                    r.ev = ldhb_pkg::EV_SEND_HEARTBEAT;
                end
            end
        end
        else if (!session_down)
        begin
            if (parse_pos < ldhb_pkg::LEN_BYTES)
            begin
                frame_len = {frame_len[23:0], value};
                parse_pos = parse_pos + 17'd1;
                if (parse_pos == ldhb_pkg::LEN_BYTES &&
                    (frame_len < ldhb_pkg::MIN_FRAME_LEN || frame_len > frame_limit()))
                begin
                    session_down = 1'b1;
                    r.ev = ldhb_pkg::EV_LENGTH_CLOSE;
                end
            end
            else if (parse_pos < ldhb_pkg::HDR_BYTES)
            begin
                frame_ident = {frame_ident[7:0], value};
                parse_pos = parse_pos + 17'd1;
                // A frame that is only a header ends on its second id byte.
                if (parse_pos == ldhb_pkg::HDR_BYTES && frame_len == ldhb_pkg::MIN_FRAME_LEN)
                begin
                    parse_pos = '0;
                    r.ev = frame_end_event();
                    if (r.ev == ldhb_pkg::EV_EMPTY_FRAME)
                        r.id = frame_ident;
                end
            end
            else
            begin
                parse_pos = parse_pos + 17'd1;
                if ({15'd0, parse_pos} >= frame_len)
                begin
                    parse_pos = '0;
                    frame_len = '0;
                    r.ev = frame_end_event();
                    // The last byte of a data frame carries the payload with last set.
                    if (r.ev == ldhb_pkg::EV_EMPTY_FRAME)
                    begin
                        r.ev = ldhb_pkg::EV_PAYLOAD;
                        r.data = value;
                        r.id = frame_ident;
                        r.last = 1'b1;
                    end
                end
                else if (frame_ident != shadow_cfg.heartbeat_request_id &&
                         frame_ident != shadow_cfg.hb_reply_id)
                begin
                    r.ev = ldhb_pkg::EV_PAYLOAD;
                    r.data = value;
                    r.id = frame_ident;
                end
            end
        end
        r.ping = ping_value;
        return r;
    endfunction

    // True when the next tick would close the session for lack of a reply.
    function automatic bit tick_closes();
        logic [31:0] since;

        since = clock_ms + 32'd1 - hb_sent_ms;
        return !session_down && shadow_cfg.heartbeat_enable && hb_sent_ms > hb_seen_ms &&
               since > shadow_cfg.reply_timeout_ms;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, expected, actual);
            mismatches++;
        end
    endfunction

    task automatic queue_beat(input logic kind, input logic [7:0] value);
        ingress_beat_t b;

        b.kind = kind;
        b.data = value;
        pending_beats.push_back(b);
        predicted_events.push_back(deframe_step(kind, value));
        beats_queued++;
    endtask

    // Queues one whole frame with random payload. Ticks are sprinkled between the
    // bytes, except where a tick would end the session by timeout.
    task automatic queue_frame(input logic [31:0] len, input logic [15:0] id);
        logic [47:0] hdr;

        hdr = {len, id};
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < tick_pct && !tick_closes())
                queue_beat(ldhb_pkg::KIND_TICK, 8'($urandom));
            if (i < ldhb_pkg::HDR_BYTES)
                queue_beat(ldhb_pkg::KIND_BYTE, hdr[47 - 8 * i -: 8]);
            else
                queue_beat(ldhb_pkg::KIND_BYTE, 8'($urandom_range(255)));
        end
    endtask

    // Well-formed frames only: lengths stay within the limit in force. When a
    // heartbeat is outstanding, replies become much more likely.
    task automatic random_frames(input int unsigned count, input int unsigned tick_rate);
        int unsigned stop;
        int unsigned pick;
        logic [31:0] limit;
        logic [31:0] short_cap;
        logic [31:0] long_cap;
        logic [31:0] len;
        logic [15:0] id;

        stop = beats_queued + count;
        tick_pct = tick_rate;
        while (beats_queued < stop)
        begin
            limit = frame_limit();
            short_cap = (limit < 24) ? limit : 32'd24;
            long_cap = (limit < 400) ? limit : 32'd400;
            pick = $urandom_range(99);
            if (pick < 20)
                len = ldhb_pkg::MIN_FRAME_LEN;
            else if (pick < 28 && limit <= 400)
                len = limit;
            else if (pick < 32)
                len = ldhb_pkg::MIN_FRAME_LEN +
                      $urandom_range(long_cap - ldhb_pkg::MIN_FRAME_LEN);
            else
                len = ldhb_pkg::MIN_FRAME_LEN +
                      $urandom_range(short_cap - ldhb_pkg::MIN_FRAME_LEN);

            pick = $urandom_range(99);
            if (hb_sent_ms > hb_seen_ms && pick < 50)
                id = shadow_cfg.hb_reply_id;
            else if (pick < 65)
                id = shadow_cfg.heartbeat_request_id;
            else if (pick < 80)
                id = shadow_cfg.hb_reply_id;
            else
                id = 16'($urandom);
            queue_frame(len, id);
        end
    endtask

    // Waits until every queued beat has gone in and every result beat has come out.
    task automatic wait_idle();
        while (pending_beats.size() != 0 || predicted_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [ldhb_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ldhb_pkg::REG_MAX_FRAME_LENGTH: shadow_cfg.max_frame_length = value[16:0];
            ldhb_pkg::REG_HB_REQUEST_ID:    shadow_cfg.heartbeat_request_id = value[15:0];
            ldhb_pkg::REG_HB_REPLY_ID:      shadow_cfg.hb_reply_id = value[15:0];
            ldhb_pkg::REG_REPLY_TIMEOUT:    shadow_cfg.reply_timeout_ms = value;
            ldhb_pkg::REG_SEND_INTERVAL:    shadow_cfg.send_interval_ms = value;
            ldhb_pkg::REG_HB_ENABLE:        shadow_cfg.heartbeat_enable = value[0];
            default: ;
        endcase
    endtask

    // Registers are only rewritten once the parser has gone quiet, so the sender
    // pauses here until every result beat has arrived.
    task automatic configure(input logic [31:0] max_len, input logic [31:0] req_id,
                             input logic [31:0] rep_id, input logic [31:0] timeout_ms,
                             input logic [31:0] interval_ms, input logic enable);
        wait_idle();
        reg_write(ldhb_pkg::REG_MAX_FRAME_LENGTH, max_len);
        reg_write(ldhb_pkg::REG_HB_REQUEST_ID, req_id);
        reg_write(ldhb_pkg::REG_HB_REPLY_ID, rep_id);
        reg_write(ldhb_pkg::REG_REPLY_TIMEOUT, timeout_ms);
        reg_write(ldhb_pkg::REG_SEND_INTERVAL, interval_ms);
        reg_write(ldhb_pkg::REG_HB_ENABLE, {31'd0, enable});
    endtask

    // Driver: presents the oldest pending beat and holds it until it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            beat_in.valid <= 1'b0;
            beat_in.kind <= ldhb_pkg::KIND_BYTE;
            beat_in.data_byte <= 8'd0;
        end
        else if (!beat_in.valid || beat_in.ready)
        begin
            if (pending_beats.size() > 0 && (steady || $urandom_range(99) >= 23))
            begin
                next_beat = pending_beats.pop_front();
                beat_in.valid <= 1'b1;
                beat_in.kind <= next_beat.kind;
                beat_in.data_byte <= next_beat.data;
            end
            else
            begin
                beat_in.valid <= 1'b0;
            end
        end
    end

    // Monitor: every result beat taken is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            beat_out.ready <= 1'b0;
        end
        else
        begin
            if (beat_out.valid && beat_out.ready)
            begin
                if (predicted_events.size() == 0)
                begin
                    $error("result beat with event %0d arrived with none outstanding",
                           beat_out.event_res);
                    mismatches++;
                end
                else
                begin
                    want = predicted_events.pop_front();
                    check_field("event_res", 32'(want.ev), 32'(beat_out.event_res));
                    check_field("out_byte", 32'(want.data), 32'(beat_out.out_byte));
                    check_field("frame_id", 32'(want.id), 32'(beat_out.frame_id));
                    check_field("last", 32'(want.last), 32'(beat_out.last));
                    check_field("ping_ms", want.ping, beat_out.ping_ms);
                end
            end
            beat_out.ready <= steady || ($urandom_range(99) >= 23);
        end
    end

    // Counts cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((beat_in.valid && beat_in.ready) || (beat_out.valid && beat_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("length_prefixed_deframer_heartbeat_core: mismatch");
        $finish;
    end

    initial
    begin
        logic [15:0] id_a;
        logic [15:0] id_b;
        logic [31:0] bad_len;
        logic [31:0] limit;

        beat_in.valid = 1'b0;
        beat_in.kind = ldhb_pkg::KIND_BYTE;
        beat_in.data_byte = 8'd0;
        beat_out.ready = 1'b0;
        shadow_cfg = '{max_frame_length: ldhb_pkg::RST_MAX_FRAME_LENGTH,
                       heartbeat_request_id: ldhb_pkg::RST_HB_REQUEST_ID,
                       hb_reply_id: ldhb_pkg::RST_HB_REPLY_ID,
                       reply_timeout_ms: ldhb_pkg::RST_REPLY_TIMEOUT,
                       send_interval_ms: ldhb_pkg::RST_SEND_INTERVAL,
                       heartbeat_enable: ldhb_pkg::RST_HB_ENABLE};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset configuration. The first results must
        // report no ping yet; the reply frame then measures one.
        tick_pct = 0;
        queue_frame(7, 16'h1234);
        queue_frame(6, 16'hFFFF);
        queue_frame(6, ldhb_pkg::RST_HB_REQUEST_ID);
        queue_beat(ldhb_pkg::KIND_TICK, 8'hFF);
        queue_frame(7, ldhb_pkg::RST_HB_REPLY_ID);

        // Shortest possible limit and a heartbeat on every tick; replies never
        // time out.
        configure(32'd6, 32'h0000, 32'hFFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
        random_frames(120, 30);

        // Short interval and timeout with distinct random heartbeat ids.
        id_a = 16'($urandom);
        id_b = id_a + 16'd1 + 16'($urandom_range(65534));
        configure(32'd40, {16'd0, id_a}, {16'd0, id_b}, 32'd30, 32'd7, 1'b1);
        random_frames(300, 25);

        // Largest register value (clamped by the cap), equal heartbeat ids, and an
        // interval that is never reached.
        id_a = 16'($urandom);
        configure(32'd131071, {16'd0, id_a}, {16'd0, id_a}, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1);
        random_frames(250, 10);

        // Supervision off: ticks only move the clock.
        configure(32'($urandom_range(200, 6)), $urandom_range(65535), $urandom_range(65535),
                  32'd0, 32'd0, 1'b0);
        random_frames(150, 30);

        // Zero timeout: once a heartbeat is out, only a reply keeps the session up.
        configure(32'd64, 32'hFFFF, 32'h0000, 32'd0, 32'd3, 1'b1);
        random_frames(250, 30);

        // Closing is permanent, so the run ends with one way of closing, chosen at
        // random, followed by traffic that a closed session must ignore.
        if ($urandom_range(1) == 1)
        begin
            case ($urandom_range(2))
                0:       configure(32'd6, shadow_cfg.heartbeat_request_id,
                                   shadow_cfg.hb_reply_id, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1);
                1:       configure(32'($urandom_range(5000, 6)), shadow_cfg.heartbeat_request_id,
                                   shadow_cfg.hb_reply_id, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1);
                default: configure(32'd131071, shadow_cfg.heartbeat_request_id,
                                   shadow_cfg.hb_reply_id, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1);
            endcase
            limit = frame_limit();
            case ($urandom_range(2))
                0:       bad_len = $urandom_range(ldhb_pkg::MIN_FRAME_LEN - 1);
                1:       bad_len = limit + 32'd1;
                default: bad_len = $urandom | 32'h8000_0000;
            endcase
            for (int i = 0; i < ldhb_pkg::LEN_BYTES; i++)
                queue_beat(ldhb_pkg::KIND_BYTE, bad_len[31 - 8 * i -: 8]);
        end
        else
        begin
            configure({15'd0, shadow_cfg.max_frame_length}, shadow_cfg.heartbeat_request_id,
                      shadow_cfg.hb_reply_id, $urandom_range(20), $urandom_range(20),
                      1'b1);
            // With no replies coming, a timeout close follows within a few dozen ticks.
            while (!session_down)
                queue_beat(ldhb_pkg::KIND_TICK, 8'($urandom));
        end
        for (int i = 0; i < 40; i++)
            queue_beat(1'($urandom_range(1)), 8'($urandom_range(255)));

        wait_idle();
        if (mismatches == 0)
            $display("length_prefixed_deframer_heartbeat_core: match");
        else
            $display("length_prefixed_deframer_heartbeat_core: mismatch");
        $finish;
    end

endmodule

[files.f]
hdl/ldhb_pkg.sv
hdl/ldhb_intf.sv
hdl/ldhb_cfg.sv
hdl/ldhb_engine.sv
hdl/length_prefixed_deframer_heartbeat_core.sv
tb/tb.sv
